// File: sv/cidt_pkg.sv
// Shared types and constants for the sorted CAN identifier table.
// Used by cidt_mem, cidt_ctrl and sorted_can_id_table_unit.
`default_nettype none
package cidt_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int ID_W           = 29;
  localparam int PAY_W          = 64;
  localparam int SLOT_W         = 4;
  localparam int OP_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_STORE  = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_CMP,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              was_new;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
  } result_t;

endpackage
`default_nettype wire

// File: sv/cidt_mem.sv
// Table storage: one write port, one registered read port, per-entry valid bits.
// Entries that are not valid read as zero. Depends on cidt_pkg.
`default_nettype none
module cidt_mem
  import cidt_pkg::*;
#(
  parameter int DEPTH = TABLE_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  input  wire logic          clr,
  output entry_t             rdata
);

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  entry_t             rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q  <= mem[raddr];
      rvalid_q <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

// File: sv/cidt_ctrl.sv
// Sequencer for the table: identifier scan, insertion shift, read and clear.
// Equality and less-than identifier comparators on the read data serve scan and shift. Depends on cidt_pkg.
`default_nettype none
module cidt_ctrl
  import cidt_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int AW         = $clog2(TABLE_SIZE),
  parameter int CNT_W      = $clog2(TABLE_SIZE + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [ID_W-1:0]   frame_id,
  input  wire logic [PAY_W-1:0]  frame_payload,
  input  wire logic [SLOT_W-1:0] read_slot,
  output logic                   res_valid,
  input  wire logic              res_take,
  output result_t                res,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output entry_t                 mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  output logic                   mem_clr,
  input  wire entry_t            mem_rdata
);

  localparam logic [AW-1:0]    LAST   = AW'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] SIZE_C = CNT_W'(TABLE_SIZE);

  state_t               state;
  state_t               state_next;
  op_t                  op_q;
  logic [ID_W-1:0]      fid_q;
  logic [PAY_W-1:0]     fpay_q;
  logic [SLOT_W-1:0]    rs_q;
  logic [CNT_W-1:0]     scan_idx;
  logic [AW-1:0]        chk_idx;
  logic                 rd_pend;
  logic [AW-1:0]        pos;
  logic                 id_eq;
  logic                 id_lt;
  logic                 match;
  logic                 rs_in_range;
  entry_t               frame;

  assign id_eq       = mem_rdata.id == fid_q;
  assign id_lt       = mem_rdata.id < fid_q;
  assign match       = rd_pend && id_eq;
  assign rs_in_range = int'(read_slot) < TABLE_SIZE;
  assign frame       = '{id: fid_q, payload: fpay_q};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(operation))
            OP_STORE: state_next = ST_SCAN;
            OP_READ:  state_next = rs_in_range ? ST_READ_RD : ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_DONE;
        end else if (rd_pend && chk_idx == LAST) begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD:  state_next = (pos == LAST) ? ST_DONE : ST_SHIFT_CMP;
      ST_SHIFT_CMP: state_next = id_lt ? ST_SHIFT_RD : ST_DONE;
      ST_READ_RD:   state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = frame;
    mem_re    = 1'b0;
    mem_raddr = scan_idx[AW-1:0];
    mem_clr   = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: begin
        mem_re    = scan_idx < SIZE_C;
        mem_we    = match;
        mem_waddr = chk_idx;
      end
      ST_SHIFT_RD: begin
        if (pos == LAST) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos + AW'(1);
        end
      end
      ST_SHIFT_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = id_lt ? mem_rdata : frame;
      end
      ST_READ_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(rs_q);
      end
      ST_DONE: begin
        res_valid = 1'b1;
        mem_clr   = op_q == OP_CLEAR;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (in_valid) begin
            op_q     <= op_t'(operation);
            fid_q    <= frame_id;
            fpay_q   <= frame_payload;
            rs_q     <= read_slot;
            scan_idx <= '0;
            res      <= '{slot: (op_t'(operation) == OP_READ) ? read_slot : {SLOT_W{1'b0}},
                          was_new: 1'b0, id: {ID_W{1'b0}}, payload: {PAY_W{1'b0}}};
          end
        end
        ST_SCAN: begin
          rd_pend <= mem_re;
          chk_idx <= scan_idx[AW-1:0];
          pos     <= '0;
          if (mem_re) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (match) begin
            res <= '{slot: SLOT_W'(chk_idx), was_new: 1'b0, id: fid_q, payload: fpay_q};
          end
        end
        ST_SHIFT_RD: begin
          if (pos == LAST) begin
            res <= '{slot: SLOT_W'(pos), was_new: 1'b1, id: fid_q, payload: fpay_q};
          end
        end
        ST_SHIFT_CMP: begin
          if (id_lt) begin
            pos <= pos + AW'(1);
          end else begin
            res <= '{slot: SLOT_W'(pos), was_new: 1'b1, id: fid_q, payload: fpay_q};
          end
        end
        ST_READ_WAIT: begin
          res <= '{slot: rs_q, was_new: 1'b0, id: mem_rdata.id, payload: mem_rdata.payload};
        end
        default: rd_pend <= rd_pend;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_clr))
    else $error("table write and clear in the same cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != ST_IDLE)
    else $error("sequencer idle right after an input transfer");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result dropped or changed");

  a_shift_read_then_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT_RD && mem_re) |=> state == ST_SHIFT_CMP)
    else $error("shift read not followed by compare");
`endif

endmodule
`default_nettype wire

// File: sv/sorted_can_id_table_unit.sv
// Top level of the sorted CAN identifier table: sequencer, storage and output register.
// Depends on cidt_pkg, cidt_mem and cidt_ctrl.
//
// The table holds TABLE_SIZE frames sorted ascending by identifier. A store first scans
// the slots through the single registered memory read port, one slot per cycle, until
// an identifier match or the last slot; on a miss it then walks up from slot 0, reading
// and comparing each entry it moves. Reads pass through a memory read state and a wait
// state; clears, unused operations and out-of-range reads go straight to the result. The
// input is stalled while an item is in work; a finished result waits in the output
// register without holding up the next transfer in. Reset and clear empty the table at
// once through per-slot valid bits.
`default_nettype none
module sorted_can_id_table_unit
  import cidt_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [ID_W-1:0]   frame_id,
  input  wire logic [PAY_W-1:0]  frame_payload,
  input  wire logic [SLOT_W-1:0] read_slot,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [SLOT_W-1:0]      slot,
  output logic                   was_new,
  output logic [ID_W-1:0]        entry_id,
  output logic [PAY_W-1:0]       entry_payload
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic          in_ready;
  logic          res_valid;
  logic          res_take;
  result_t       res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_clr;
  entry_t        mem_rdata;

  cidt_ctrl #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .frame_id(frame_id),
    .frame_payload(frame_payload),
    .read_slot(read_slot),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_clr(mem_clr),
    .mem_rdata(mem_rdata)
  );

  cidt_mem #(
    .DEPTH(TABLE_SIZE),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .clr(mem_clr),
    .rdata(mem_rdata)
  );

  assign in_stall = !in_ready;
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      slot          <= res.slot;
      was_new       <= res.was_new;
      entry_id      <= res.id;
      entry_payload <= res.payload;
    end
  end

endmodule
`default_nettype wire
